// ===== sv/sfida_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfida_pkg
// Shared types and constants of the slot aware flow id allocator.
// ----------------------------------------------------------------------------
package sfida_pkg;

    localparam int DEF_NUM_IDS    = 4096;
    localparam int DEF_NUM_SLOTS  = 512;
    localparam int DEF_NUM_GROUPS = 4;

    localparam int ID_FIELD_W = 12;
    localparam int GROUP_W    = 2;
    localparam int USAGE_W    = 13;

    localparam logic [USAGE_W-1:0] USAGE_MAX = 13'd8191;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef struct packed {
        logic                  command;
        logic [GROUP_W-1:0]    group;
        logic [ID_FIELD_W-1:0] free_id;
    } t_req;

    typedef struct packed {
        logic                  status;
        logic [ID_FIELD_W-1:0] granted_id;
    } t_rsp;

endpackage
`default_nettype wire

// ===== sv/sfida_chan_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfida_chan_if
// Valid/ready channel carrying one request or response payload.
// ----------------------------------------------------------------------------
interface sfida_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/slot_aware_flow_id_allocator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slot_aware_flow_id_allocator_unit
// Allocate: paced by the usage count scan (one count a cycle) and the free
//   list walk (one link read a cycle).
// Free: the two-step reciprocal slot remainder, then the link and count updates.
// One request at a time; the next is taken the cycle after the response loads.
// Reset: synchronous, then a clearing pass over max(NUM_IDS, NUM_GROUPS*NUM_SLOTS)
//   entries rebuilds the free list and zeroes the counts before ready rises.
// ----------------------------------------------------------------------------
module slot_aware_flow_id_allocator_unit #(
    parameter int NUM_IDS    = sfida_pkg::DEF_NUM_IDS,
    parameter int NUM_SLOTS  = sfida_pkg::DEF_NUM_SLOTS,
    parameter int NUM_GROUPS = sfida_pkg::DEF_NUM_GROUPS
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    sfida_chan_if.sink   i_req,
    sfida_chan_if.source o_rsp
);

    localparam int ID_W       = $clog2(NUM_IDS);
    localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int USE_DEPTH  = NUM_GROUPS * NUM_SLOTS;
    localparam int USE_AW     = (USE_DEPTH > 1) ? $clog2(USE_DEPTH) : 1;
    localparam int INIT_DEPTH = (NUM_IDS > USE_DEPTH) ? NUM_IDS : USE_DEPTH;
    localparam int INIT_W     = $clog2(INIT_DEPTH);
    localparam int STEP_W     = $clog2(NUM_IDS + 1);
    localparam int USAGE_W    = sfida_pkg::USAGE_W;

    // slot remainder by reciprocal multiplication
    localparam int     REM_SH  = ID_W + $clog2(NUM_SLOTS);
    localparam longint RECIP_L = ((longint'(1) << REM_SH) + longint'(NUM_SLOTS) - 1)
                                 / longint'(NUM_SLOTS);
    localparam logic [ID_W+1:0] RECIP    = (ID_W + 2)'(RECIP_L);
    localparam logic [ID_W-1:0] SLOTS_ID = ID_W'(NUM_SLOTS);

    localparam logic [SLOT_W-1:0] SLOT_ONE  = SLOT_W'(1 % NUM_SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

    localparam logic [3:0] ST_INIT   = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_SCAN   = 4'd2;
    localparam logic [3:0] ST_WALK   = 4'd3;
    localparam logic [3:0] ST_UNLINK = 4'd4;
    localparam logic [3:0] ST_POP    = 4'd5;
    localparam logic [3:0] ST_POP2   = 4'd6;
    localparam logic [3:0] ST_INC_RD = 4'd7;
    localparam logic [3:0] ST_INC_WR = 4'd8;
    localparam logic [3:0] ST_MOD    = 4'd9;
    localparam logic [3:0] ST_FLINK  = 4'd10;
    localparam logic [3:0] ST_FDEC   = 4'd11;
    localparam logic [3:0] ST_DONE   = 4'd12;
    localparam logic [3:0] ST_REM    = 4'd13;

    typedef struct packed {
        logic              ok;
        logic [ID_W-1:0]   id;
        logic [SLOT_W-1:0] slot;
    } t_link;

    function automatic logic [GRP_W-1:0] grp_wrap(input logic [1:0] g);
        logic [2:0] v;
        v = {1'b0, g};
        for (int k = 0; k < 4; k++) begin
            if (32'(v) >= NUM_GROUPS) begin
                v = v - 3'(NUM_GROUPS);
            end
        end
        return GRP_W'(v);
    endfunction

    // memories
    t_link              r_link_mem [NUM_IDS];
    logic [USAGE_W-1:0] r_use_mem  [USE_DEPTH];
    t_link              r_link_q;
    logic [USAGE_W-1:0] r_use_q;

    logic               link_we;
    logic [ID_W-1:0]    link_addr;
    t_link              link_wd;
    logic               use_we;
    logic [USE_AW-1:0]  use_addr;
    logic [USAGE_W-1:0] use_wd;

    // control
    logic [3:0]        r_state,     n_state;
    logic [INIT_W-1:0] r_init,      n_init;
    logic [SLOT_W-1:0] r_init_slot, n_init_slot;
    logic [ID_W-1:0]   r_head,      n_head;
    logic              r_head_ok,   n_head_ok;
    logic [SLOT_W-1:0] r_head_slot, n_head_slot;
    logic              r_chk_vld,   n_chk_vld;
    logic              r_ovld,      n_ovld;

    // payload
    logic [USE_AW-1:0]  r_base,   n_base;
    logic [ID_W-1:0]    r_fid,    n_fid;
    logic [SLOT_W-1:0]  r_issue,  n_issue;
    logic [SLOT_W-1:0]  r_chk,    n_chk;
    logic [SLOT_W-1:0]  r_s,      n_s;
    logic [ID_W-1:0]    r_prev,   n_prev;
    logic [STEP_W-1:0]  r_steps,  n_steps;
    logic [ID_W-1:0]    r_grant,  n_grant;
    logic [SLOT_W-1:0]  r_uslot,  n_uslot;
    logic               r_status, n_status;
    logic [ID_W-1:0]    r_div,    n_div;
    sfida_pkg::t_rsp    r_odata,  n_odata;

    logic [2*ID_W+1:0]  quo_p;
    logic [ID_W-1:0]    rem_w;

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = r_ovld;
    assign o_rsp.data  = r_odata;

    always_comb begin
        quo_p = {{(ID_W + 2){1'b0}}, r_fid} * {{ID_W{1'b0}}, RECIP};
        rem_w = r_fid - r_div * SLOTS_ID;
    end

    always_comb begin
        n_state     = r_state;
        n_init      = r_init;
        n_init_slot = r_init_slot;
        n_head      = r_head;
        n_head_ok   = r_head_ok;
        n_head_slot = r_head_slot;
        n_chk_vld   = r_chk_vld;
        n_ovld      = r_ovld && !o_rsp.ready;
        n_base      = r_base;
        n_fid       = r_fid;
        n_issue     = r_issue;
        n_chk       = r_chk;
        n_s         = r_s;
        n_prev      = r_prev;
        n_steps     = r_steps;
        n_grant     = r_grant;
        n_uslot     = r_uslot;
        n_status    = r_status;
        n_div       = r_div;
        n_odata     = r_odata;

        link_we      = 1'b0;
        link_addr    = r_head;
        link_wd.ok   = r_head_ok;
        link_wd.id   = r_head;
        link_wd.slot = r_head_slot;
        use_we       = 1'b0;
        use_addr     = r_base + USE_AW'(r_uslot);
        use_wd       = '0;

        unique case (r_state)
            ST_INIT: begin
                link_we      = (32'(r_init) < NUM_IDS);
                link_addr    = r_init[ID_W-1:0];
                link_wd.ok   = (r_init != '0) && (32'(r_init) + 32'd1 < NUM_IDS);
                link_wd.id   = ID_W'(r_init + INIT_W'(1));
                link_wd.slot = r_init_slot;
                use_we       = (32'(r_init) < USE_DEPTH);
                use_addr     = r_init[USE_AW-1:0];
                n_init       = r_init + INIT_W'(1);
                n_init_slot  = (r_init_slot == SLOT_LAST) ? '0 : r_init_slot + SLOT_W'(1);
                if (r_init == INIT_W'(INIT_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_base   = USE_AW'(grp_wrap(i_req.data.group) * NUM_SLOTS);
                    n_grant  = '0;
                    n_status = sfida_pkg::STATUS_DONE;
                    if (i_req.data.command == sfida_pkg::CMD_FREE) begin
                        n_fid = ID_W'(i_req.data.free_id);
                        if (32'(i_req.data.free_id) < NUM_IDS) begin
                            n_state = ST_MOD;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end else if (!r_head_ok) begin
                        n_status = sfida_pkg::STATUS_EMPTY;
                        n_state  = ST_DONE;
                    end else begin
                        n_issue   = '0;
                        n_chk_vld = 1'b0;
                        n_state   = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                use_addr = r_base + USE_AW'(r_issue);
                if (r_chk_vld && r_use_q == '0) begin
                    if (r_head_slot == r_chk) begin
                        n_grant = r_head;
                        n_uslot = r_head_slot;
                        n_state = ST_POP2;
                    end else begin
                        n_prev  = r_head;
                        n_steps = STEP_W'(1);
                        n_s     = r_chk;
                        n_state = ST_WALK;
                    end
                end else if (r_chk_vld && r_chk == SLOT_LAST) begin
                    n_grant = r_head;
                    n_uslot = r_head_slot;
                    n_state = ST_POP2;
                end else begin
                    n_issue   = (r_issue == SLOT_LAST) ? r_issue : r_issue + SLOT_W'(1);
                    n_chk     = r_issue;
                    n_chk_vld = 1'b1;
                end
            end
            ST_WALK: begin
                link_addr = r_link_q.id;
                if (r_steps == STEP_W'(NUM_IDS) || !r_link_q.ok) begin
                    n_grant = r_head;
                    n_uslot = r_head_slot;
                    n_state = ST_POP;
                end else if (r_link_q.slot == r_s) begin
                    n_grant = r_link_q.id;
                    n_uslot = r_s;
                    n_state = ST_UNLINK;
                end else begin
                    n_prev  = r_link_q.id;
                    n_steps = r_steps + STEP_W'(1);
                end
            end
            ST_UNLINK: begin
                link_we   = 1'b1;
                link_addr = r_prev;
                link_wd   = r_link_q;
                n_state   = ST_INC_RD;
            end
            ST_POP: begin
                n_state = ST_POP2;
            end
            ST_POP2: begin
                n_head_ok   = r_link_q.ok;
                n_head      = r_link_q.ok ? r_link_q.id : '0;
                n_head_slot = r_link_q.ok ? r_link_q.slot : '0;
                n_state     = ST_INC_RD;
            end
            ST_INC_RD: begin
                n_state = ST_INC_WR;
            end
            ST_INC_WR: begin
                use_we  = 1'b1;
                use_wd  = (r_use_q == sfida_pkg::USAGE_MAX) ? r_use_q
                                                            : r_use_q + USAGE_W'(1);
                n_state = ST_DONE;
            end
            ST_MOD: begin
                n_div   = ID_W'(quo_p >> REM_SH);
                n_state = ST_REM;
            end
            ST_REM: begin
                n_uslot = SLOT_W'(rem_w);
                n_state = ST_FLINK;
            end
            ST_FLINK: begin
                link_we     = 1'b1;
                link_addr   = r_fid;
                n_head      = r_fid;
                n_head_ok   = 1'b1;
                n_head_slot = r_uslot;
                n_state     = ST_FDEC;
            end
            ST_FDEC: begin
                use_we  = 1'b1;
                use_wd  = (r_use_q == '0) ? r_use_q : r_use_q - USAGE_W'(1);
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_ovld || o_rsp.ready) begin
                    n_ovld             = 1'b1;
                    n_odata.status     = r_status;
                    n_odata.granted_id = sfida_pkg::ID_FIELD_W'(r_grant);
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link_mem[link_addr] <= link_wd;
        end
        r_link_q <= r_link_mem[link_addr];
    end

    always_ff @(posedge i_clk) begin
        if (use_we) begin
            r_use_mem[use_addr] <= use_wd;
        end
        r_use_q <= r_use_mem[use_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_init      <= '0;
            r_init_slot <= SLOT_ONE;
            r_head      <= ID_W'(1);
            r_head_ok   <= 1'b1;
            r_head_slot <= SLOT_ONE;
            r_chk_vld   <= 1'b0;
            r_ovld      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_init_slot <= n_init_slot;
            r_head      <= n_head;
            r_head_ok   <= n_head_ok;
            r_head_slot <= n_head_slot;
            r_chk_vld   <= n_chk_vld;
            r_ovld      <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base   <= n_base;
        r_fid    <= n_fid;
        r_issue  <= n_issue;
        r_chk    <= n_chk;
        r_s      <= n_s;
        r_prev   <= n_prev;
        r_steps  <= n_steps;
        r_grant  <= n_grant;
        r_uslot  <= n_uslot;
        r_status <= n_status;
        r_div    <= n_div;
        r_odata  <= n_odata;
    end

endmodule
`default_nettype wire
